### sv/packbits_column_major_unpacker_defines.svh
// Assertion macros shared by the unpacker RTL.
`ifndef PACKBITS_COLUMN_MAJOR_UNPACKER_DEFINES_SVH
`define PACKBITS_COLUMN_MAJOR_UNPACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PBCU_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PBCU_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### sv/pbcu_pkg.sv
// Shared types and constants for the column-major PackBits unpacker.
`timescale 1ns / 1ps

package pbcu_pkg;

  localparam int ADDR_W = 32;
  localparam int DIM_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // PackBits no-operation code
  localparam logic [7:0] CODE_NOP = 8'h80;

  // Commands to the position unit
  typedef struct packed {
    logic clear;
    logic step;
  } pos_ctrl_t;

endpackage

### sv/pbcu_position.sv
// Position unit: walks row-major pixels and yields column-major addresses.
`timescale 1ns / 1ps

module pbcu_position import pbcu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pos_ctrl_t         ctrl,
  input  logic [DIM_W-1:0]  load_width,
  input  logic [DIM_W-1:0]  height,
  output logic [ADDR_W-1:0] address,
  output logic              done
);

  logic [DIM_W-1:0]  columns_left;
  logic [DIM_W-1:0]  current_row;
  logic [ADDR_W-1:0] next_address;

  logic [DIM_W-1:0]  cols_dec;
  logic [DIM_W-1:0]  row_inc;
  logic [ADDR_W-1:0] addr_add;
  logic              row_end;

  // Shared step arithmetic: one column count, one row compare, one address add
  assign cols_dec = columns_left - DIM_W'(1);
  assign row_inc  = current_row + DIM_W'(1);
  assign addr_add = next_address + ADDR_W'(height);
  assign row_end  = (cols_dec == '0);
  assign done     = ctrl.step && row_end && (row_inc >= height);
  assign address  = next_address;

  // Advance one pixel, or restart the image
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_left <= DIM_W'(1);
      current_row  <= '0;
      next_address <= '0;
    end else if (ctrl.clear || done) begin
      columns_left <= load_width;
      current_row  <= '0;
      next_address <= '0;
    end else if (ctrl.step) begin
      if (row_end) begin
        columns_left <= load_width;
        current_row  <= row_inc;
        next_address <= ADDR_W'(row_inc);
      end else begin
        columns_left <= cols_dec;
        next_address <= addr_add;
      end
    end
  end

endmodule

### sv/packbits_column_major_unpacker.sv
// Top level of the column-major PackBits unpacker.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte) takes one payload word per
//   accepted handshake. Output channel (out_valid/out_ready) returns one word
//   per result: a pixel value with one or two column-major addresses.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   width, height and mode; any valid write to one of these restarts the image at row 0.
// Sequencing:
//   A code byte is accepted and yields nothing. A pixel byte (raw or
//   literal) is accepted, then takes one step of the position unit, then
//   loads the output register. A repeat value of n pixels yields ceil(n/2)
//   results, up to 64, fewer if the image ends first: the single position
//   adder steps the pixels, up to two per result, and each result then loads
//   the output register. in_ready is high only while the sequencer is idle; the
//   output register still holding a word does not hold off the next accept.
// Reset: rst (synchronous) sets width and height to 1, raw mode, row 0.
// Stall: while out_ready is low the finished word holds and the sequencer
//   waits with the next result staged.
`timescale 1ns / 1ps
`include "packbits_column_major_unpacker_defines.svh"

module packbits_column_major_unpacker import pbcu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           pixel_index,
  output logic [ADDR_W-1:0]    first_address,
  output logic                 second_valid,
  output logic [ADDR_W-1:0]    second_address,
  output logic                 last_of_run,
  output logic                 image_done
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FIRST  = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]       state;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             compressed_mode;
  logic [7:0]       literal_left;
  logic             expect_repeat_value;
  logic [7:0]       repeat_count;
  logic [7:0]       count;
  logic [7:0]       value;

  logic [ADDR_W-1:0] st_a1;
  logic [ADDR_W-1:0] st_a2;
  logic              st_v2;
  logic              st_last;
  logic              st_done;

  logic              cfg_hit;
  logic [DIM_W-1:0]  width_src;
  logic [DIM_W-1:0]  eff_width;
  logic [DIM_W-1:0]  eff_height;
  logic              in_fire;
  logic              out_free;
  logic              pixel_byte;
  pos_ctrl_t         pos_ctrl;
  logic [ADDR_W-1:0] pos_addr;
  logic              pos_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Decode a write to a register of the list
  always_comb begin
    case (cfg_index)
      REG_WIDTH, REG_HEIGHT, REG_MODE: cfg_hit = cfg_valid;
      default:                         cfg_hit = 1'b0;
    endcase
  end

  // Zero size counts as one; restart width follows a write in flight
  assign width_src  = (cfg_valid && cfg_index == REG_WIDTH) ? cfg_data : image_width;
  assign eff_width  = (width_src == '0) ? DIM_W'(1) : width_src;
  assign eff_height = (image_height == '0) ? DIM_W'(1) : image_height;

  assign pixel_byte = !compressed_mode || (literal_left != '0) || expect_repeat_value;

  assign pos_ctrl.clear = cfg_hit;
  assign pos_ctrl.step  = (state == S_FIRST) || (state == S_SECOND);

  pbcu_position u_position (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pos_ctrl),
    .load_width (eff_width),
    .height     (eff_height),
    .address    (pos_addr),
    .done       (pos_done)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= DIM_W'(1);
      image_height    <= DIM_W'(1);
      compressed_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  image_width     <= cfg_data;
        REG_HEIGHT: image_height    <= cfg_data;
        REG_MODE:   compressed_mode <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Sequencer and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      literal_left        <= '0;
      expect_repeat_value <= 1'b0;
      repeat_count        <= '0;
      count               <= '0;
    end else if (cfg_hit) begin
      literal_left        <= '0;
      expect_repeat_value <= 1'b0;
      repeat_count        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (!compressed_mode || literal_left != '0) begin
              if (compressed_mode) literal_left <= literal_left - 8'd1;
              count <= 8'd1;
              state <= S_FIRST;
            end else if (expect_repeat_value) begin
              count               <= repeat_count;
              expect_repeat_value <= 1'b0;
              repeat_count        <= '0;
              state               <= S_FIRST;
            end else if (data_byte < CODE_NOP) begin
              literal_left <= data_byte + 8'd1;
            end else if (data_byte != CODE_NOP) begin
              repeat_count        <= 8'(9'd257 - {1'b0, data_byte});
              expect_repeat_value <= 1'b1;
            end
          end
        end
        S_FIRST: begin
          count <= count - 8'd1;
          if (pos_done || count == 8'd1) state <= S_EMIT;
          else                           state <= S_SECOND;
          if (pos_done) literal_left <= '0;
        end
        S_SECOND: begin
          count <= count - 8'd1;
          state <= S_EMIT;
          if (pos_done) literal_left <= '0;
        end
        S_EMIT: begin
          if (out_free) state <= st_last ? S_IDLE : S_FIRST;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the pixel value and stage the result
  always_ff @(posedge clk) begin
    if (in_fire) value <= data_byte;
    case (state)
      S_FIRST: begin
        st_a1   <= pos_addr;
        st_a2   <= '0;
        st_v2   <= 1'b0;
        st_last <= pos_done || count == 8'd1;
        st_done <= pos_done;
      end
      S_SECOND: begin
        st_a2   <= pos_addr;
        st_v2   <= 1'b1;
        st_last <= pos_done || count == 8'd1;
        st_done <= pos_done;
      end
      default: ;
    endcase
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      pixel_index    <= value;
      first_address  <= st_a1;
      second_valid   <= st_v2;
      second_address <= st_a2;
      last_of_run    <= st_last;
      image_done     <= st_done;
    end
  end

  `PBCU_ASSERT_NOW(a_second_has_pixel, state == S_SECOND, count != '0, "second step with no pixel left")
  `PBCU_ASSERT_NOW(a_done_is_last, out_valid && image_done, last_of_run, "image end not last of run")
  `PBCU_ASSERT_NOW(a_single_zero_addr, out_valid && !second_valid, second_address == '0, "stale second address")
  `PBCU_ASSERT_NOW(a_repeat_count_range, expect_repeat_value, repeat_count >= 8'd2, "bad repeat count")
  `PBCU_ASSERT_NEXT(a_pixel_starts_step, in_fire && pixel_byte && !cfg_hit, state == S_FIRST, "pixel word did not start a step")

endmodule
